[design/cau_pkg.sv]
// cau_pkg: shared types and constants of the complex arithmetic unit
// no dependencies; used by every module of the unit
`default_nettype none

package cau_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_MUL   = 3'd2,
    KIND_DIV   = 3'd3,
    KIND_SQR   = 3'd4,
    KIND_RECIP = 3'd5,
    KIND_NEG   = 3'd6,
    KIND_CMP   = 3'd7
  } kind_e;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic eq;
    logic ovf_re;
    logic ovf_im;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

`default_nettype wire

[design/complex_arith_unit.sv]
// complex_arith_unit: pipelined complex alu on signed fixed-point operands
// one word accepted every cycle while the output register is not stalled
// the pipeline length is set by the divider chain: one quotient bit per stage, DATA_WIDTH stages
// every op walks the same pipeline, so results leave in order
// async active-low reset clears the control words (valid bits and flags); payload regs are not reset
// depends on cau_pkg, cau_mul_stage, cau_div_stage
`default_nettype none

module complex_arith_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [2:0]                kind_i,
  input  wire logic signed [DATA_WIDTH-1:0] first_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] first_im_i,
  input  wire logic signed [DATA_WIDTH-1:0] second_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] second_im_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic signed [DATA_WIDTH-1:0]   result_re_o,
  output logic signed [DATA_WIDTH-1:0]   result_im_o,
  output logic                           divide_by_zero_o,
  output logic                           saturated_o,
  output logic                           is_zero_o,
  output logic                           operands_equal_o
);

  localparam int unsigned W    = DATA_WIDTH;
  // wide enough for (ac+bd)<<F, a<<2F and den<<W with sign
  localparam int unsigned NW   = 3 * W + 2 * FRAC_BITS + 2;
  localparam int unsigned DENW = 2 * W;

  // whole pipe advances together; the output register holds a word under stall
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: input register and equality flag
  cau_pkg::ctl_t       ctl1_d, ctl1_q;
  cau_pkg::kind_e      kind1_q;
  logic signed [W-1:0] a1_q, b1_q, c1_q, d1_q;

  always_comb begin
    ctl1_d       = '0;
    ctl1_d.valid = in_valid_i;
    ctl1_d.eq    = (first_re_i == second_re_i) && (first_im_i == second_im_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en) begin
      ctl1_q <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= cau_pkg::kind_e'(kind_i);
      a1_q    <= first_re_i;
      b1_q    <= first_im_i;
      c1_q    <= second_re_i;
      d1_q    <= second_im_i;
    end
  end

  // stages 2 and 3: products, then sums and fixed-point shifts
  cau_pkg::ctl_t        ctl3;
  logic signed [NW-1:0] val3_re, val3_im;
  logic [DENW-1:0]      den3;

  cau_mul_stage #(
    .W    (W),
    .F    (FRAC_BITS),
    .NW   (NW),
    .DENW (DENW)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (ctl1_q),
    .kind_i   (kind1_q),
    .a_i      (a1_q),
    .b_i      (b1_q),
    .c_i      (c1_q),
    .d_i      (d1_q),
    .ctl_o    (ctl3),
    .val_re_o (val3_re),
    .val_im_o (val3_im),
    .den_o    (den3)
  );

  // stage 4: sign split and zero-divisor check for the divider
  cau_pkg::ctl_t   ctl4_d, ctl4_q;
  logic [NW-1:0]   rem4_re_d, rem4_im_d, rem4_re_q, rem4_im_q;
  logic [DENW-1:0] den4_q;

  always_comb begin
    ctl4_d        = ctl3;
    ctl4_d.dz     = ctl3.is_div && (den3 == '0);
    ctl4_d.neg_re = val3_re[NW-1];
    ctl4_d.neg_im = val3_im[NW-1];
    rem4_re_d     = val3_re;
    rem4_im_d     = val3_im;
    if (ctl3.is_div) begin
      // divisor is a sum of squares, so only the numerator carries sign
      if (val3_re[NW-1]) rem4_re_d = -val3_re;
      if (val3_im[NW-1]) rem4_im_d = -val3_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (en) begin
      ctl4_q <= ctl4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem4_re_q <= rem4_re_d;
      rem4_im_q <= rem4_im_d;
      den4_q    <= den3;
    end
  end

  // stage 5: a quotient of 2^W or more can only saturate
  cau_pkg::ctl_t ctl5_d;
  logic [NW-1:0] den_top;

  always_comb begin
    den_top       = NW'(den4_q) << W;
    ctl5_d        = ctl4_q;
    ctl5_d.ovf_re = ctl4_q.is_div && (rem4_re_q >= den_top);
    ctl5_d.ovf_im = ctl4_q.is_div && (rem4_im_q >= den_top);
  end

  cau_pkg::ctl_t   ctl_c    [W+1];
  logic [NW-1:0]   rem_re_c [W+1];
  logic [NW-1:0]   rem_im_c [W+1];
  logic [W-1:0]    q_re_c   [W+1];
  logic [W-1:0]    q_im_c   [W+1];
  logic [DENW-1:0] den_c    [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c[0] <= '0;
    end else if (en) begin
      ctl_c[0] <= ctl5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_re_c[0] <= rem4_re_q;
      rem_im_c[0] <= rem4_im_q;
      den_c[0]    <= den4_q;
    end
  end

  assign q_re_c[0] = '0;
  assign q_im_c[0] = '0;

  // divider chain: msb quotient bit first
  for (genvar k = 0; k < W; k++) begin : g_div
    cau_div_stage #(
      .W    (W),
      .NW   (NW),
      .DENW (DENW),
      .BIT  (W - 1 - k)
    ) u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (ctl_c[k]),
      .rem_re_i (rem_re_c[k]),
      .rem_im_i (rem_im_c[k]),
      .q_re_i   (q_re_c[k]),
      .q_im_i   (q_im_c[k]),
      .den_i    (den_c[k]),
      .ctl_o    (ctl_c[k+1]),
      .rem_re_o (rem_re_c[k+1]),
      .rem_im_o (rem_im_c[k+1]),
      .q_re_o   (q_re_c[k+1]),
      .q_im_o   (q_im_c[k+1]),
      .den_o    (den_c[k+1])
    );
  end

  // clamp a wide signed value to W bits; msb of the result is the saturation flag
  function automatic logic [W:0] clamp_fn(input logic [NW-1:0] v);
    logic [W:0] r;
    if ((v[NW-1:W-1] == '0) || (v[NW-1:W-1] == '1)) begin
      r = {1'b0, v[W-1:0]};
    end else begin
      r = {1'b1, v[NW-1], {(W-1){~v[NW-1]}}};
    end
    return r;
  endfunction

  function automatic logic [W:0] div_fn(input logic [W-1:0] q, input logic neg,
                                        input logic ovf);
    logic [NW-1:0] qz;
    logic [W:0]    r;
    qz = NW'(q);
    if (ovf) begin
      r = {1'b1, neg, {(W-1){~neg}}};
    end else begin
      r = clamp_fn(neg ? -qz : qz);
    end
    return r;
  endfunction

  // output stage
  cau_pkg::ctl_t ctl_f;
  logic [W:0]    re_f, im_f;

  always_comb begin
    ctl_f = ctl_c[W];
    if (ctl_f.is_div) begin
      if (ctl_f.dz) begin
        re_f = '0;
        im_f = '0;
      end else begin
        re_f = div_fn(q_re_c[W], ctl_f.neg_re, ctl_f.ovf_re);
        im_f = div_fn(q_im_c[W], ctl_f.neg_im, ctl_f.ovf_im);
      end
    end else begin
      re_f = clamp_fn(rem_re_c[W]);
      im_f = clamp_fn(rem_im_c[W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_re_o      <= re_f[W-1:0];
      result_im_o      <= im_f[W-1:0];
      divide_by_zero_o <= ctl_f.is_div && ctl_f.dz;
      saturated_o      <= re_f[W] || im_f[W];
      is_zero_o        <= (re_f[W-1:0] == '0) && (im_f[W-1:0] == '0);
      operands_equal_o <= ctl_f.eq;
    end
  end

  // a zero divisor always gives a clean zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |->
      result_re_o == '0 && result_im_o == '0 && is_zero_o && !saturated_o)
    else $error("divide by zero word is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_zero_o == ((result_re_o == '0) && (result_im_o == '0)))
    else $error("zero flag disagrees with result");

  // a word stalled at the output keeps its flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(saturated_o) && $stable(divide_by_zero_o) && $stable(operands_equal_o))
    else $error("flags changed under stall");

endmodule

`default_nettype wire

[design/cau_mul_stage.sv]
// cau_mul_stage: product stage and sum/shift stage of the unit
// depends on cau_pkg
`default_nettype none

module cau_mul_stage #(
  parameter int unsigned W    = cau_pkg::DataWidthDef,
  parameter int unsigned F    = cau_pkg::FracBitsDef,
  parameter int unsigned NW   = 3 * W + 2 * F + 2,
  parameter int unsigned DENW = 2 * W
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire cau_pkg::ctl_t          ctl_i,
  input  wire cau_pkg::kind_e         kind_i,
  input  wire logic signed [W-1:0]    a_i,
  input  wire logic signed [W-1:0]    b_i,
  input  wire logic signed [W-1:0]    c_i,
  input  wire logic signed [W-1:0]    d_i,
  output cau_pkg::ctl_t               ctl_o,
  output logic signed [NW-1:0]        val_re_o,
  output logic signed [NW-1:0]        val_im_o,
  output logic [DENW-1:0]             den_o
);

  // square and reciprocal reuse the multiply datapath with second := first
  logic signed [W-1:0] cm, dm;
  cau_pkg::ctl_t       ctl2_d;

  cau_pkg::ctl_t        ctl2_q;
  cau_pkg::kind_e       kind2_q;
  logic signed [W-1:0]  a2_q, b2_q, c2_q;
  logic signed [2*W-1:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;

  always_comb begin
    cm = c_i;
    dm = d_i;
    if (kind_i == cau_pkg::KIND_SQR || kind_i == cau_pkg::KIND_RECIP) begin
      cm = a_i;
      dm = b_i;
    end
    ctl2_d = ctl_i;
    ctl2_d.is_div = (kind_i == cau_pkg::KIND_DIV) || (kind_i == cau_pkg::KIND_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind_i;
      a2_q    <= a_i;
      b2_q    <= b_i;
      c2_q    <= c_i;
      ac_q    <= a_i * cm;
      bd_q    <= b_i * dm;
      ad_q    <= a_i * dm;
      bc_q    <= b_i * cm;
      cc_q    <= cm * cm;
      dd_q    <= dm * dm;
    end
  end

  logic signed [NW-1:0] ac_w, bd_w, ad_w, bc_w, a_w, b_w, c_w;
  logic signed [NW-1:0] re_d, im_d;
  logic [DENW-1:0]      den_d;
  logic signed [NW-1:0] d_w;

  // imaginary second part of add/sub needs d as well
  logic signed [W-1:0] d2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q <= d_i;
    end
  end

  always_comb begin
    ac_w  = NW'(ac_q);
    bd_w  = NW'(bd_q);
    ad_w  = NW'(ad_q);
    bc_w  = NW'(bc_q);
    a_w   = NW'(a2_q);
    b_w   = NW'(b2_q);
    c_w   = NW'(c2_q);
    d_w   = NW'(d2_q);
    den_d = $unsigned(cc_q) + $unsigned(dd_q);
    case (kind2_q)
      cau_pkg::KIND_ADD: begin
        re_d = a_w + c_w;
        im_d = b_w + d_w;
      end
      cau_pkg::KIND_SUB: begin
        re_d = a_w - c_w;
        im_d = b_w - d_w;
      end
      cau_pkg::KIND_MUL, cau_pkg::KIND_SQR: begin
        re_d = (ac_w - bd_w) >>> F;
        im_d = (ad_w + bc_w) >>> F;
      end
      cau_pkg::KIND_DIV: begin
        re_d = (ac_w + bd_w) <<< F;
        im_d = (bc_w - ad_w) <<< F;
      end
      cau_pkg::KIND_RECIP: begin
        re_d = a_w <<< (2 * F);
        im_d = (-b_w) <<< (2 * F);
      end
      cau_pkg::KIND_NEG: begin
        re_d = -a_w;
        im_d = -b_w;
      end
      default: begin
        re_d = a_w;
        im_d = b_w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_re_o <= re_d;
      val_im_o <= im_d;
      den_o    <= den_d;
    end
  end

endmodule

`default_nettype wire

[design/cau_div_stage.sv]
// cau_div_stage: one restoring-division step for both parts, one quotient bit
// depends on cau_pkg
`default_nettype none

module cau_div_stage #(
  parameter int unsigned W    = cau_pkg::DataWidthDef,
  parameter int unsigned NW   = 3 * W + 2 * cau_pkg::FracBitsDef + 2,
  parameter int unsigned DENW = 2 * W,
  parameter int unsigned BIT  = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire cau_pkg::ctl_t   ctl_i,
  input  wire logic [NW-1:0]   rem_re_i,
  input  wire logic [NW-1:0]   rem_im_i,
  input  wire logic [W-1:0]    q_re_i,
  input  wire logic [W-1:0]    q_im_i,
  input  wire logic [DENW-1:0] den_i,
  output cau_pkg::ctl_t        ctl_o,
  output logic [NW-1:0]        rem_re_o,
  output logic [NW-1:0]        rem_im_o,
  output logic [W-1:0]         q_re_o,
  output logic [W-1:0]         q_im_o,
  output logic [DENW-1:0]      den_o
);

  logic [NW-1:0] den_sh, rem_re_d, rem_im_d;
  logic [W-1:0]  q_re_d, q_im_d;
  logic          take_re, take_im;

  // non-divide words ride through untouched
  always_comb begin
    den_sh   = NW'(den_i) << BIT;
    take_re  = ctl_i.is_div && (rem_re_i >= den_sh);
    take_im  = ctl_i.is_div && (rem_im_i >= den_sh);
    rem_re_d = take_re ? rem_re_i - den_sh : rem_re_i;
    rem_im_d = take_im ? rem_im_i - den_sh : rem_im_i;
    q_re_d   = q_re_i;
    q_im_d   = q_im_i;
    q_re_d[BIT] = take_re;
    q_im_d[BIT] = take_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
      den_o    <= den_i;
    end
  end

endmodule

`default_nettype wire

[dv/cau_checker.sv]
// cau_checker: watches both channels of complex_arith_unit, predicts every result word
// and compares it field by field; depends on cau_pkg for the opcode enum
module cau_checker #(
  parameter int unsigned DW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [2:0]           kind_i,
  input  logic signed [DW-1:0] first_re_i,
  input  logic signed [DW-1:0] first_im_i,
  input  logic signed [DW-1:0] second_re_i,
  input  logic signed [DW-1:0] second_im_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [DW-1:0] result_re_i,
  input  logic signed [DW-1:0] result_im_i,
  input  logic                 divide_by_zero_i,
  input  logic                 saturated_i,
  input  logic                 is_zero_i,
  input  logic                 operands_equal_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 sat;
    logic                 zero;
    logic                 eq;
  } cplx_res_t;

  localparam wide_t MaxV = (wide_t'(1) <<< (DW - 1)) - 1;
  localparam wide_t MinV = -(wide_t'(1) <<< (DW - 1));

  cplx_res_t expected_q[$];
  int        errors;
  int        checked;
  int        pending;

  function automatic wide_t clamp_part(wide_t x);
    if (x > MaxV) return MaxV;
    if (x < MinV) return MinV;
    return x;
  endfunction

  // exact wide arithmetic, one rounding at the end of each op
  function automatic cplx_res_t compute_complex(cau_pkg::kind_e k, logic signed [DW-1:0] fr,
                                                logic signed [DW-1:0] fi,
                                                logic signed [DW-1:0] sr,
                                                logic signed [DW-1:0] si);
    wide_t     a, b, c, d, re, im, den, cre, cim;
    cplx_res_t r;
    a = fr; b = fi; c = sr; d = si;
    re = '0; im = '0;
    r.dz = 1'b0;
    case (k)
      cau_pkg::KIND_ADD: begin re = a + c; im = b + d; end
      cau_pkg::KIND_SUB: begin re = a - c; im = b - d; end
      cau_pkg::KIND_MUL: begin
        re = (a * c - b * d) >>> FB;
        im = (a * d + b * c) >>> FB;
      end
      cau_pkg::KIND_DIV: begin
        den = c * c + d * d;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = ((a * c + b * d) <<< FB) / den;
          im = ((b * c - a * d) <<< FB) / den;
        end
      end
      cau_pkg::KIND_SQR: begin
        re = (a * a - b * b) >>> FB;
        im = ((a * b) <<< 1) >>> FB;
      end
      cau_pkg::KIND_RECIP: begin
        den = a * a + b * b;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = (a <<< (2 * FB)) / den;
          im = ((-b) <<< (2 * FB)) / den;
        end
      end
      cau_pkg::KIND_NEG: begin re = -a; im = -b; end
      default:  begin re = a; im = b; end
    endcase
    cre = clamp_part(re);
    cim = clamp_part(im);
    r.sat  = (cre != re) || (cim != im);
    r.re   = cre[DW-1:0];
    r.im   = cim[DW-1:0];
    r.zero = (r.re == 0) && (r.im == 0);
    r.eq   = (fr == sr) && (fi == si);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cplx_res_t e;
    if (!rst_ni) begin
      expected_q.delete();
      errors  <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(compute_complex(cau_pkg::kind_e'(kind_i), first_re_i,
                                             first_im_i, second_re_i, second_im_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          checked <= checked + 1;
          if (result_re_i !== e.re || result_im_i !== e.im || divide_by_zero_i !== e.dz ||
              saturated_i !== e.sat || is_zero_i !== e.zero ||
              operands_equal_i !== e.eq) begin
            errors <= errors + 1;
            if (result_re_i !== e.re)
              $error("result_re expected %0d got %0d", e.re, result_re_i);
            if (result_im_i !== e.im)
              $error("result_im expected %0d got %0d", e.im, result_im_i);
            if (divide_by_zero_i !== e.dz)
              $error("divide_by_zero expected %0b got %0b", e.dz, divide_by_zero_i);
            if (saturated_i !== e.sat)
              $error("saturated expected %0b got %0b", e.sat, saturated_i);
            if (is_zero_i !== e.zero)
              $error("is_zero expected %0b got %0b", e.zero, is_zero_i);
            if (operands_equal_i !== e.eq)
              $error("operands_equal expected %0b got %0b", e.eq, operands_equal_i);
          end
        end
      end
      pending <= expected_q.size();
    end
  end

  assign errors_o  = errors;
  assign pending_o = pending;
  assign checked_o = checked;

endmodule

[dv/tb_complex_arith_unit.sv]
// tb_complex_arith_unit: stimulus and verdict for complex_arith_unit
// depends on cau_pkg, the unit's rtl and cau_checker, which predicts and compares
module tb_complex_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW         = 32;
  localparam int FB         = 16;
  localparam int NumRandom  = 1330;
  localparam int IdleLimit  = 3000;  // the pipeline depth plus the longest stalls, many times over
  localparam int DrainWait  = 60;

  localparam logic signed [DW-1:0] MaxF = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinF = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] One  = 1 <<< FB;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           kind;
  logic signed [DW-1:0] first_re, first_im, second_re, second_im;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [DW-1:0] result_re, result_im;
  logic                 divide_by_zero, saturated, is_zero, operands_equal;
  int                   errors, pending, checked;
  int                   words_sent;
  int                   idle_cycles;
  bit                   busy_rx;    // receiver stretch with no stalls

  complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .first_re_i       (first_re),
    .first_im_i       (first_im),
    .second_re_i      (second_re),
    .second_im_i      (second_im),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_re_o      (result_re),
    .result_im_o      (result_im),
    .divide_by_zero_o (divide_by_zero),
    .saturated_o      (saturated),
    .is_zero_o        (is_zero),
    .operands_equal_o (operands_equal)
  );

  cau_checker #(.DW(DW), .FB(FB)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .first_re_i       (first_re),
    .first_im_i       (first_im),
    .second_re_i      (second_re),
    .second_im_i      (second_im),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .result_re_i      (result_re),
    .result_im_i      (result_im),
    .divide_by_zero_i (divide_by_zero),
    .saturated_i      (saturated),
    .is_zero_i        (is_zero),
    .operands_equal_i (operands_equal),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operand part: full range, small values that keep mul/div meaningful, or an extreme
  function automatic logic signed [DW-1:0] pick_part();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return $signed($urandom) >>> $urandom_range(4, 24);
    case ($urandom_range(0, 4))
      0:       return MaxF;
      1:       return MinF;
      2:       return 0;
      3:       return One;
      default: return -One;
    endcase
  endfunction

  // present one word and hold it until the unit takes it
  task automatic send_word(cau_pkg::kind_e k, logic signed [DW-1:0] ar,
                           logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                           logic signed [DW-1:0] bi, int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind      = k;
    first_re  = ar;
    first_im  = ai;
    second_re = br;
    second_im = bi;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls, with stretches of always-ready
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) busy_rx = ~busy_rx;
    if (busy_rx) out_ready = 1'b1;
    else if ($urandom_range(0, 99) < 4) begin
      out_ready = 1'b0;
      repeat ($urandom_range(5, 40)) @(negedge clk);
    end else out_ready = ($urandom_range(0, 99) < 70);
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("FAIL complex_arith_unit");
      $finish;
    end
  end

  initial begin
    cau_pkg::kind_e       kk;
    logic signed [DW-1:0] ar, ai, br, bi;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    busy_rx     = 1'b0;
    kind        = cau_pkg::KIND_ADD;
    first_re    = '0;
    first_im    = '0;
    second_re   = '0;
    second_im   = '0;
    words_sent  = 0;
    idle_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: every op, extremes, overflow, zero divisor, negate of the minimum
    send_word(cau_pkg::KIND_ADD,   MaxF, MinF, MaxF, MinF, 0);   // both parts clamp
    send_word(cau_pkg::KIND_SUB,   MinF, MaxF, MaxF, MinF, 0);
    send_word(cau_pkg::KIND_SUB,   One, -One, One, -One, 0);     // zero result, equal operands
    send_word(cau_pkg::KIND_MUL,   MaxF, MaxF, MaxF, MaxF, 0);
    send_word(cau_pkg::KIND_MUL,   MinF, MinF, MinF, MaxF, 0);
    send_word(cau_pkg::KIND_MUL,   -1, 3, 5, -7, 0);             // tiny positive parts that shift to zero
    send_word(cau_pkg::KIND_DIV,   One, One, 0, 0, 0);           // zero divisor
    send_word(cau_pkg::KIND_DIV,   MaxF, MinF, 1, 0, 0);         // quotient overflow
    send_word(cau_pkg::KIND_DIV,   -One, 3 * One, 2 * One, -One, 0);
    send_word(cau_pkg::KIND_DIV,   -5, 7, MinF, MinF, 0);
    send_word(cau_pkg::KIND_SQR,   MinF, MinF, 0, 0, 0);
    send_word(cau_pkg::KIND_SQR,   MaxF, 0, MaxF, MaxF, 0);
    send_word(cau_pkg::KIND_SQR,   -3, 1, 4, 4, 0);
    send_word(cau_pkg::KIND_RECIP, 0, 0, One, One, 0);           // zero divisor
    send_word(cau_pkg::KIND_RECIP, 1, 0, 0, 0, 0);               // huge reciprocal clamps
    send_word(cau_pkg::KIND_RECIP, MinF, MaxF, 5, 5, 0);
    send_word(cau_pkg::KIND_RECIP, -2 * One, One, 0, 0, 0);
    send_word(cau_pkg::KIND_NEG,   MinF, MinF, 7, 7, 0);         // negating the minimum clamps
    send_word(cau_pkg::KIND_NEG,   MaxF, 0, MaxF, 0, 0);
    send_word(cau_pkg::KIND_CMP,   MinF, MaxF, MinF, MaxF, 0);
    send_word(cau_pkg::KIND_CMP,   0, 0, 1, 0, 0);
    send_word(cau_pkg::KIND_ADD,   -1, -1, -1, -1, 0);

    // random part; halfway the sender holds off until the pipe is empty
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      kk = cau_pkg::kind_e'($urandom_range(0, 7));
      ar = pick_part();
      ai = pick_part();
      if ($urandom_range(0, 9) == 0) begin
        br = ar;
        bi = ai;
      end else begin
        br = pick_part();
        bi = pick_part();
      end
      if ($urandom_range(0, 19) == 0) begin
        if (kk == cau_pkg::KIND_RECIP) begin ar = 0; ai = 0; end
        else begin br = 0; bi = 0; end
      end
      send_word(kk, ar, ai, br, bi, (n % 300 < 60) ? 0 : pick_gap());
    end
    in_valid = 1'b0;

    // drain, then keep watching in case something stray comes out
    wait (pending == 0);
    repeat (DrainWait) @(negedge clk);

    $display("sent %0d words over all eight ops, checked %0d results", words_sent, checked);
    $display("random stalls on both sides, one full drain mid-run");
    if (errors == 0 && pending == 0) begin
      $display("PASS complex_arith_unit");
    end else begin
      $display("FAIL complex_arith_unit");
    end
    $finish;
  end

endmodule

[sim.f]
design/cau_pkg.sv
design/cau_mul_stage.sv
design/cau_div_stage.sv
design/complex_arith_unit.sv
dv/cau_checker.sv
dv/tb_complex_arith_unit.sv
